>>> src/sedf_pkg.sv
package sedf_pkg;

   localparam int PIXEL_W    = 8;
   localparam int SD_W       = 14;
   localparam int SQ_W       = 18;
   localparam int DIM_W      = 9;
   localparam int THR_W      = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_WIDTH     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_HEIGHT    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD = 2'd2;

   localparam logic [DIM_W-1:0] WIDTH_RESET     = 9'd256;
   localparam logic [DIM_W-1:0] HEIGHT_RESET    = 9'd256;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd128;

endpackage

>>> src/sedf_if.sv
interface sedf_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [sedf_pkg::PIXEL_W-1:0]   pixel;
   modport source (output valid, cmd, pixel, input ready);
   modport sink (input valid, cmd, pixel, output ready);
endinterface

interface sedf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [sedf_pkg::SD_W-1:0] signed_distance;
   logic [sedf_pkg::SQ_W-1:0]      squared_distance;
   logic                           last_pixel;
   modport source (output valid, signed_distance, squared_distance, last_pixel, input ready);
   modport sink (input valid, signed_distance, squared_distance, last_pixel, output ready);
endinterface

interface sedf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sedf_pkg::CSR_ADDR_W-1:0]   index;
   logic [sedf_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/sedf_div.sv
module sedf_div #(
   parameter int N = 8,
   parameter int D = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient
);

   localparam int CNT_W = $clog2(N + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D-1:0]     rem_ff, rem_in;
   logic [N-1:0]     quo_ff, quo_in;
   logic [D-1:0]     den_ff, den_in;
   logic [D:0]       shifted;
   logic [D:0]       diff;
   logic             ge;

   // Restoring division, one quotient bit per cycle.
   assign shifted = {rem_ff, quo_ff[N-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[N-2:0], ge};
         rem_in = ge ? diff[D-1:0] : shifted[D-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/sedf_sqrt.sv
module sedf_sqrt #(
   parameter int IN_W = 26
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [IN_W-1:0] value,
   output logic            done,
   output logic [IN_W/2:0] root
);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [IN_W-1:0] n_ff, n_in;
   logic [IN_W-1:0] r_ff, r_in;
   logic [IN_W-1:0] bit_ff, bit_in;
   logic [IN_W:0]   trial;

   assign trial = {1'b0, r_ff} + {1'b0, bit_ff};

   // One result bit per step from two bits of the value; a last step rounds to nearest.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      n_in    = n_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         n_in    = value;
         r_in    = '0;
         bit_in  = IN_W'(1) << (IN_W - 2);
      end else if (busy_ff) begin
         if (bit_ff != '0) begin
            if ({1'b0, n_ff} >= trial) begin
               n_in = n_ff - trial[IN_W-1:0];
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end else begin
            if (n_ff > r_ff) begin
               r_in = r_ff + IN_W'(1);
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[IN_W/2:0];

endmodule

>>> src/signed_euclidean_distance_field_unit.sv
// Signed Euclidean distance field of a thresholded gray image.
// Configure image_width, image_height and threshold through csr_bus; any
// accepted write to a known register abandons the current image. Then send
// width*height load items (cmd 0) on req_bus in raster order, one per cycle.
// After the last pixel the block runs the column passes (down and up, a read
// state and a write state per pixel per direction) and the row lower-envelope
// passes for both classes; req_bus.ready stays low meanwhile. Going forward a
// row pass reads, fetches, multiplies and compares for each pixel, multiplies
// and compares again after each stack pop, and runs a serial division for each
// pixel after the first in its row that does not empty the stack; coming back
// it reads and writes each pixel, with one more state per stack pop.
// Each read item (cmd 1) then returns one result on rsp_bus in raster order
// after the memory read, the bit-pair square root unit and the output
// register; the next read item is taken only once this result is in the
// output register. The result marked last_pixel returns the block to loading.
// A stalled rsp_bus keeps its result registered; the next read item is taken
// and computed, then waits until the output register frees. Reads while
// loading and loads while reading are accepted and dropped. Reset returns
// to loading with default registers; no memory clearing pass is needed.
module signed_euclidean_distance_field_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 4
) (
   input logic          clock,
   input logic          reset,
   sedf_req_if.sink     req_bus,
   sedf_rsp_if.source   rsp_bus,
   sedf_csr_if.sink     csr_bus
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int DW    = (WW > HW) ? WW : HW;
   localparam int NPIX  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(NPIX);
   localparam int TW    = $clog2(NPIX + 1);
   localparam int VSQ_W = 2 * DW + 1;
   localparam int CW    = 2 * DW + 2;
   localparam int NW    = 2 * DW + 4;
   localparam int SQ_W  = sedf_pkg::SQ_W;
   localparam int SD_W  = sedf_pkg::SD_W;
   localparam int RW    = SQ_W + 2 * FRAC_BITS;
   localparam int RTW   = RW / 2 + 1;

   typedef enum logic [18:0] {
      S_LOAD  = 19'b0000000000000000001,
      S_VDRD  = 19'b0000000000000000010,
      S_VDWR  = 19'b0000000000000000100,
      S_VURD  = 19'b0000000000000001000,
      S_VUWR  = 19'b0000000000000010000,
      S_FRD   = 19'b0000000000000100000,
      S_FGET  = 19'b0000000000001000000,
      S_FMUL  = 19'b0000000000010000000,
      S_FCMP  = 19'b0000000000100000000,
      S_FPOP  = 19'b0000000001000000000,
      S_FDIV  = 19'b0000000010000000000,
      S_BRD   = 19'b0000000100000000000,
      S_BWR   = 19'b0000001000000000000,
      S_BPOP  = 19'b0000010000000000000,
      S_RIDLE = 19'b0000100000000000000,
      S_RRD   = 19'b0001000000000000000,
      S_RSQ   = 19'b0010000000000000000,
      S_RWAIT = 19'b0100000000000000000,
      S_ROUT  = 19'b1000000000000000000
   } state_type;

   typedef struct packed {
      logic [XW-1:0]    site;
      logic [XW-1:0]    start;
      logic [VSQ_W-1:0] vsq;
   } stk_entry_type;

   state_type state_ff, state_in;

   logic [sedf_pkg::DIM_W-1:0] width_ff, width_in;
   logic [sedf_pkg::DIM_W-1:0] height_ff, height_in;
   logic [sedf_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [TW-1:0]    load_cnt_ff, load_cnt_in;
   logic [TW-1:0]    read_cnt_ff, read_cnt_in;
   logic             tc_ff, tc_in;
   logic [XW-1:0]    x_ff, x_in;
   logic [YW-1:0]    y_ff, y_in;
   logic [AW-1:0]    vaddr_ff, vaddr_in;
   logic [AW-1:0]    base_ff, base_in;
   logic [HW-1:0]    prev_ff, prev_in;
   logic [XW-1:0]    q_ff, q_in;
   stk_entry_type    top_ff, top_in;
   logic [VSQ_W-1:0] vxy_ff, vxy_in;
   logic [CW-1:0]    aa_ff, aa_in;
   logic [CW-1:0]    bb_ff, bb_in;
   logic [CW-1:0]    xx_ff, xx_in;
   logic [CW-1:0]    ss_ff, ss_in;
   logic             neg_ff, neg_in;
   logic             fg_ff, fg_in;
   logic [SQ_W-1:0]  sq_val_ff, sq_val_in;
   logic [RTW-1:0]   root_ff, root_in;
   logic [VSQ_W-1:0] inf_sq_ff, inf_sq_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SD_W-1:0]  rsp_sd_ff, rsp_sd_in;
   logic [SQ_W-1:0]  rsp_sq_ff, rsp_sq_in;
   logic             rsp_last_ff, rsp_last_in;

   // Memories and their ports.
   logic             cls_mem [NPIX];
   logic             cls_rd_ff;
   logic [AW-1:0]    cls_raddr;
   logic             cls_we;
   logic [HW-1:0]    col_mem [NPIX];
   logic [HW-1:0]    col_rd_ff;
   logic [AW-1:0]    col_raddr;
   logic             col_we;
   logic [HW-1:0]    col_wdata;
   logic [SQ_W-1:0]  sq_mem [NPIX];
   logic [SQ_W-1:0]  sq_rd_ff;
   logic             sq_we;
   logic [SQ_W-1:0]  sq_wdata;
   stk_entry_type    stk_mem [MAX_WIDTH];
   stk_entry_type    stk_rd_ff;
   logic [XW-1:0]    stk_raddr;
   logic             stk_we;
   logic [XW-1:0]    stk_waddr;
   stk_entry_type    stk_wdata;

   logic [WW-1:0]    w_eff;
   logic [HW-1:0]    h_eff;
   logic [TW-1:0]    total;
   logic [AW-1:0]    row_addr;
   logic             x_last;
   logic             y_last;
   logic             req_fire;
   logic [HW-1:0]    prev_inc;
   logic [HW-1:0]    g_up;
   logic [XW-1:0]    ad_a, ad_b, ad_back;
   logic [CW-1:0]    sq_back;
   logic             pop_cond;
   logic signed [NW-1:0] num;
   logic signed [NW-1:0] num_mag;
   logic signed [NW:0]   wv;
   logic             div_start;
   logic             div_done;
   logic [NW-2:0]    div_quot;
   logic [XW:0]      div_den;
   logic             sqrt_start;
   logic             sqrt_done;
   logic [RTW-1:0]   sqrt_root;
   logic [SD_W-1:0]  sd_mag;

   function automatic logic [VSQ_W-1:0] vsquare(input logic [HW-1:0] g,
                                                input logic [HW-1:0] hh,
                                                input logic [VSQ_W-1:0] inf);
      if (g < hh) begin
         return VSQ_W'(g) * VSQ_W'(g);
      end
      return inf;
   endfunction

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
   end

   assign total     = TW'({{HW{1'b0}}, w_eff} * {{WW{1'b0}}, h_eff});
   assign inf_sq_in = VSQ_W'(w_eff) * VSQ_W'(w_eff) + VSQ_W'(h_eff) * VSQ_W'(h_eff);
   assign row_addr  = base_ff + AW'(x_ff);
   assign x_last    = (WW'(x_ff) + WW'(1)) == w_eff;
   assign y_last    = (HW'(y_ff) + HW'(1)) == h_eff;
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign prev_inc  = ((HW + 1)'(prev_ff) + (HW + 1)'(1) >= (HW + 1)'(h_eff)) ?
                      h_eff : prev_ff + HW'(1);
   assign g_up      = (col_rd_ff != '0 && prev_inc < col_rd_ff) ? prev_inc : col_rd_ff;

   assign ad_a    = (top_ff.start >= top_ff.site) ? top_ff.start - top_ff.site
                                                  : top_ff.site - top_ff.start;
   assign ad_b    = (top_ff.start >= x_ff) ? top_ff.start - x_ff : x_ff - top_ff.start;
   assign ad_back = (x_ff >= top_ff.site) ? x_ff - top_ff.site : top_ff.site - x_ff;
   assign sq_back = CW'(ad_back) * CW'(ad_back) + CW'(top_ff.vsq);
   assign pop_cond = (aa_ff + CW'(top_ff.vsq)) > (bb_ff + CW'(vxy_ff));

   assign num = $signed(NW'(xx_ff)) - $signed(NW'(ss_ff))
              + $signed(NW'(vxy_ff)) - $signed(NW'(top_ff.vsq));
   assign num_mag = num[NW-1] ? -num : num;
   assign div_den = {x_ff - top_ff.site, 1'b0};
   assign div_start = (state_ff == S_FCMP) && !pop_cond;
   assign wv = neg_ff ? $signed((NW + 1)'(1)) - $signed((NW + 1)'(div_quot))
                      : $signed((NW + 1)'(1)) + $signed((NW + 1)'(div_quot));

   assign sqrt_start = (state_ff == S_RSQ);
   assign sd_mag = SD_W'(root_ff);

   sedf_div #(
      .N (NW - 1),
      .D (XW + 1)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag[NW-2:0]),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   sedf_sqrt #(
      .IN_W (RW)
   ) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (RW'(sq_rd_ff) << (2 * FRAC_BITS)),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // Read address selection for the shared memory ports.
   always_comb begin
      case (state_ff)
         S_VDRD:  cls_raddr = vaddr_ff;
         S_BRD:   cls_raddr = row_addr;
         default: cls_raddr = read_cnt_ff[AW-1:0];
      endcase
      case (state_ff)
         S_VURD:  col_raddr = vaddr_ff;
         default: col_raddr = row_addr;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      thr_in       = thr_ff;
      load_cnt_in  = load_cnt_ff;
      read_cnt_in  = read_cnt_ff;
      tc_in        = tc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      vaddr_in     = vaddr_ff;
      base_in      = base_ff;
      prev_in      = prev_ff;
      q_in         = q_ff;
      top_in       = top_ff;
      vxy_in       = vxy_ff;
      aa_in        = aa_ff;
      bb_in        = bb_ff;
      xx_in        = xx_ff;
      ss_in        = ss_ff;
      neg_in       = neg_ff;
      fg_in        = fg_ff;
      sq_val_in    = sq_val_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_sd_in    = rsp_sd_ff;
      rsp_sq_in    = rsp_sq_ff;
      rsp_last_in  = rsp_last_ff;
      cls_we       = 1'b0;
      col_we       = 1'b0;
      col_wdata    = '0;
      sq_we        = 1'b0;
      sq_wdata     = SQ_W'(sq_back);
      stk_we       = 1'b0;
      stk_waddr    = '0;
      stk_wdata    = '{site: x_ff, start: '0, vsq: vxy_ff};
      stk_raddr    = q_ff - XW'(1);

      case (state_ff)
         S_LOAD: begin
            if (req_fire && req_bus.cmd == sedf_pkg::CMD_LOAD) begin
               cls_we = 1'b1;
               if (load_cnt_ff + TW'(1) >= total) begin
                  load_cnt_in = '0;
                  tc_in       = 1'b0;
                  x_in        = '0;
                  y_in        = '0;
                  vaddr_in    = '0;
                  prev_in     = h_eff;
                  state_in    = S_VDRD;
               end else begin
                  load_cnt_in = load_cnt_ff + TW'(1);
               end
            end
         end
         S_VDRD: state_in = S_VDWR;
         S_VDWR: begin
            col_we    = 1'b1;
            col_wdata = (cls_rd_ff == tc_ff) ? '0 : prev_inc;
            prev_in   = col_wdata;
            if (y_last) begin
               prev_in  = h_eff;
               state_in = S_VURD;
            end else begin
               y_in     = y_ff + YW'(1);
               vaddr_in = vaddr_ff + AW'(w_eff);
               state_in = S_VDRD;
            end
         end
         S_VURD: state_in = S_VUWR;
         S_VUWR: begin
            col_we    = 1'b1;
            col_wdata = g_up;
            prev_in   = g_up;
            if (y_ff == '0) begin
               if (x_last) begin
                  x_in     = '0;
                  base_in  = '0;
                  state_in = S_FRD;
               end else begin
                  x_in     = x_ff + XW'(1);
                  vaddr_in = AW'(x_ff) + AW'(1);
                  prev_in  = h_eff;
                  state_in = S_VDRD;
               end
            end else begin
               y_in     = y_ff - YW'(1);
               vaddr_in = vaddr_ff - AW'(w_eff);
               state_in = S_VURD;
            end
         end
         S_FRD: state_in = S_FGET;
         S_FGET: begin
            vxy_in = vsquare(col_rd_ff, h_eff, inf_sq_ff);
            if (x_ff == '0) begin
               q_in      = '0;
               top_in    = '{site: '0, start: '0, vsq: vxy_in};
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = top_in;
               if (x_last) begin
                  state_in = S_BRD;
               end else begin
                  x_in     = x_ff + XW'(1);
                  state_in = S_FRD;
               end
            end else begin
               state_in = S_FMUL;
            end
         end
         S_FMUL: begin
            aa_in    = CW'(ad_a) * CW'(ad_a);
            bb_in    = CW'(ad_b) * CW'(ad_b);
            xx_in    = CW'(x_ff) * CW'(x_ff);
            ss_in    = CW'(top_ff.site) * CW'(top_ff.site);
            state_in = S_FCMP;
         end
         S_FCMP: begin
            if (pop_cond) begin
               if (q_ff == '0) begin
                  // Stack emptied: the new site covers the row from the left edge.
                  top_in    = '{site: x_ff, start: '0, vsq: vxy_ff};
                  stk_we    = 1'b1;
                  stk_waddr = '0;
                  stk_wdata = top_in;
                  if (x_last) begin
                     state_in = S_BRD;
                  end else begin
                     x_in     = x_ff + XW'(1);
                     state_in = S_FRD;
                  end
               end else begin
                  q_in     = q_ff - XW'(1);
                  state_in = S_FPOP;
               end
            end else begin
               neg_in   = num[NW-1];
               state_in = S_FDIV;
            end
         end
         S_FPOP: begin
            top_in   = stk_rd_ff;
            state_in = S_FMUL;
         end
         S_FDIV: begin
            if (div_done) begin
               if (wv < $signed((NW + 1)'(w_eff))) begin
                  q_in      = q_ff + XW'(1);
                  top_in    = '{site: x_ff, start: wv[XW-1:0], vsq: vxy_ff};
                  stk_we    = 1'b1;
                  stk_waddr = q_in;
                  stk_wdata = top_in;
               end
               if (x_last) begin
                  state_in = S_BRD;
               end else begin
                  x_in     = x_ff + XW'(1);
                  state_in = S_FRD;
               end
            end
         end
         S_BRD: state_in = S_BWR;
         S_BWR, S_BPOP: begin
            if (state_ff == S_BWR) begin
               sq_we = (cls_rd_ff != tc_ff);
            end else begin
               top_in = stk_rd_ff;
            end
            if (state_ff == S_BWR && x_ff == top_ff.start && q_ff != '0) begin
               q_in     = q_ff - XW'(1);
               state_in = S_BPOP;
            end else if (x_ff != '0) begin
               x_in     = x_ff - XW'(1);
               state_in = S_BRD;
            end else if (!y_last) begin
               y_in     = y_ff + YW'(1);
               base_in  = base_ff + AW'(w_eff);
               x_in     = '0;
               state_in = S_FRD;
            end else if (tc_ff == 1'b0) begin
               tc_in    = 1'b1;
               x_in     = '0;
               y_in     = '0;
               vaddr_in = '0;
               prev_in  = h_eff;
               state_in = S_VDRD;
            end else begin
               read_cnt_in = '0;
               state_in    = S_RIDLE;
            end
         end
         S_RIDLE: begin
            if (req_fire && req_bus.cmd == sedf_pkg::CMD_READ) begin
               state_in = S_RRD;
            end
         end
         S_RRD: state_in = S_RSQ;
         S_RSQ: begin
            fg_in     = cls_rd_ff;
            sq_val_in = sq_rd_ff;
            state_in  = S_RWAIT;
         end
         S_RWAIT: begin
            if (sqrt_done) begin
               root_in  = sqrt_root;
               state_in = S_ROUT;
            end
         end
         S_ROUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sd_in    = fg_ff ? sd_mag : -sd_mag;
               rsp_sq_in    = sq_val_ff;
               rsp_last_in  = (read_cnt_ff + TW'(1) >= total);
               if (rsp_last_in) begin
                  load_cnt_in = '0;
                  read_cnt_in = '0;
                  state_in    = S_LOAD;
               end else begin
                  read_cnt_in = read_cnt_ff + TW'(1);
                  state_in    = S_RIDLE;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase

      // A write to a known register restarts image loading.
      if (csr_bus.valid) begin
         case (csr_bus.index)
            sedf_pkg::REG_WIDTH: begin
               width_in = csr_bus.data;
            end
            sedf_pkg::REG_HEIGHT: begin
               height_in = csr_bus.data;
            end
            sedf_pkg::REG_THRESHOLD: begin
               thr_in = csr_bus.data[sedf_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
         if (csr_bus.index == sedf_pkg::REG_WIDTH || csr_bus.index == sedf_pkg::REG_HEIGHT ||
             csr_bus.index == sedf_pkg::REG_THRESHOLD) begin
            state_in    = S_LOAD;
            load_cnt_in = '0;
            read_cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cls_we) begin
         cls_mem[load_cnt_ff[AW-1:0]] <= (req_bus.pixel >= thr_ff);
      end
      cls_rd_ff <= cls_mem[cls_raddr];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[vaddr_ff] <= col_wdata;
      end
      col_rd_ff <= col_mem[col_raddr];
   end

   always_ff @(posedge clock) begin
      if (sq_we) begin
         sq_mem[row_addr] <= sq_wdata;
      end
      sq_rd_ff <= sq_mem[read_cnt_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         width_ff     <= sedf_pkg::WIDTH_RESET;
         height_ff    <= sedf_pkg::HEIGHT_RESET;
         thr_ff       <= sedf_pkg::THRESHOLD_RESET;
         load_cnt_ff  <= '0;
         read_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         thr_ff       <= thr_in;
         load_cnt_ff  <= load_cnt_in;
         read_cnt_ff  <= read_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tc_ff       <= tc_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      vaddr_ff    <= vaddr_in;
      base_ff     <= base_in;
      prev_ff     <= prev_in;
      q_ff        <= q_in;
      top_ff      <= top_in;
      vxy_ff      <= vxy_in;
      aa_ff       <= aa_in;
      bb_ff       <= bb_in;
      xx_ff       <= xx_in;
      ss_ff       <= ss_in;
      neg_ff      <= neg_in;
      fg_ff       <= fg_in;
      sq_val_ff   <= sq_val_in;
      root_ff     <= root_in;
      inf_sq_ff   <= inf_sq_in;
      rsp_sd_ff   <= rsp_sd_in;
      rsp_sq_ff   <= rsp_sq_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_bus.ready            = (state_ff == S_LOAD) || (state_ff == S_RIDLE);
   assign csr_bus.ready            = 1'b1;
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.signed_distance  = $signed(rsp_sd_ff);
   assign rsp_bus.squared_distance = rsp_sq_ff;
   assign rsp_bus.last_pixel       = rsp_last_ff;

endmodule
